[sv/wsdf_pkg.sv]
`timescale 1ns / 1ps

package wsdf_pkg;

    // Header length codes and register reset value
    localparam logic [6:0]  LEN_EXT16         = 7'd126;
    localparam logic [6:0]  LEN_EXT64         = 7'd127;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

    // Opcodes that get a verdict of their own
    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    // Request queue between parser and result formatter
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_HDR0 = 4'd0,
        PH_HDR1 = 4'd1,
        PH_EXT0 = 4'd2,
        PH_EXT1 = 4'd3,
        PH_KEY0 = 4'd4,
        PH_KEY1 = 4'd5,
        PH_KEY2 = 4'd6,
        PH_KEY3 = 4'd7,
        PH_DATA = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        VD_DELIVER = 3'd0,
        VD_PONG    = 3'd1,
        VD_IGNORE  = 3'd2,
        VD_DROP    = 3'd3,
        VD_CLOSE   = 3'd4
    } verdict_t;

    typedef enum logic [2:0] {
        RS_CLIENT   = 3'd0,
        RS_FRAG     = 3'd1,
        RS_TOO_LONG = 3'd2,
        RS_MISMATCH = 3'd3,
        RS_BAD_OP   = 3'd4
    } reason_t;

    typedef enum logic {
        KIND_BYTE    = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       segment_end;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [3:0]  frame_opcode;
        logic [2:0]  verdict;
        logic [2:0]  close_reason;
        logic [15:0] client_close_code;
        logic [15:0] payload_length;
        logic        last_of_run;
    } out_item_t;

    // One queued request: what a single input byte gives
    typedef struct packed {
        logic        has_byte;
        logic        has_verdict;
        logic [7:0]  payload_byte;
        logic [3:0]  frame_opcode;
        logic [15:0] payload_length;
        verdict_t    verdict;
        reason_t     close_reason;
        logic [15:0] close_code;
    } entry_t;

endpackage

[sv/websocket_frame_deframer.sv]
`timescale 1ns / 1ps

// Client-to-server frame receiver: one byte per request, one frame per segment.
// The parser takes a byte every clock (in_ready drops only when the request
// queue is full) and turns it into at most one queued request; the result
// formatter drains that queue at one result per clock while out_ready is high.
// A byte normally gives zero or one result, so the block runs at one byte per
// cycle while out_ready is high; the last payload byte of a frame gives two
// (payload byte, then verdict), an extra result that is absorbed by the
// four-entry queue. Results always leave from the queue head. After any close
// verdict, input is still accepted but discarded until reset. max_payload is
// written through cfg_write_en/cfg_write_data and resets to 1024.
module websocket_frame_deframer
    import wsdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item
);

    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   head_valid;
    entry_t head_entry;
    logic   pop;

    wsdf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_entry     (push_entry)
    );

    wsdf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    wsdf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

[sv/wsdf_front.sv]
`timescale 1ns / 1ps

module wsdf_front
    import wsdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        push_valid,
    input  logic        push_ready,
    output entry_t      push_entry
);

    logic            closing_reg, closing_next;
    phase_t          phase_reg, phase_next;
    logic [3:0]      opcode_reg, opcode_next;
    logic            mask_on_reg, mask_on_next;
    logic [3:0][7:0] key_reg, key_next;
    logic [15:0]     length_reg, length_next;
    logic [15:0]     byte_count_reg, byte_count_next;
    logic [15:0]     code_reg, code_next;
    logic [15:0]     max_payload_reg;

    logic        accept;
    logic [7:0]  b;
    logic [7:0]  unmasked;
    logic [15:0] ext_len;
    logic        close_now;
    reason_t     close_why;
    logic        emit_byte;
    logic        emit_verdict;
    verdict_t    verdict;
    reason_t     reason;
    logic [15:0] close_code;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign b        = in_item.data_byte;
    assign ext_len  = {length_reg[15:8], b};
    assign unmasked = b ^ (mask_on_reg ? key_reg[byte_count_reg[1:0]] : 8'h00);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_payload_reg <= MAX_PAYLOAD_RESET;
        else if (cfg_write_en)
            max_payload_reg <= cfg_write_data;
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closing_reg    <= 1'b0;
            phase_reg      <= PH_HDR0;
            opcode_reg     <= 4'd0;
            mask_on_reg    <= 1'b0;
            key_reg        <= '0;
            length_reg     <= 16'd0;
            byte_count_reg <= 16'd0;
            code_reg       <= 16'd0;
        end
        else
        begin
            closing_reg    <= closing_next;
            phase_reg      <= phase_next;
            opcode_reg     <= opcode_next;
            mask_on_reg    <= mask_on_next;
            key_reg        <= key_next;
            length_reg     <= length_next;
            byte_count_reg <= byte_count_next;
            code_reg       <= code_next;
        end
    end

    // Per-byte header parse, unmasking, close checks and end-of-segment verdict
    always_comb
    begin
        closing_next    = closing_reg;
        phase_next      = phase_reg;
        opcode_next     = opcode_reg;
        mask_on_next    = mask_on_reg;
        key_next        = key_reg;
        length_next     = length_reg;
        byte_count_next = byte_count_reg;
        code_next       = code_reg;
        close_now       = 1'b0;
        close_why       = RS_CLIENT;
        emit_byte       = 1'b0;
        emit_verdict    = 1'b0;
        verdict         = VD_DELIVER;
        reason          = RS_CLIENT;
        close_code      = 16'd0;

        if (accept && !closing_reg)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    opcode_next     = b[3:0];
                    mask_on_next    = 1'b0;
                    key_next        = '0;
                    length_next     = 16'd0;
                    byte_count_next = 16'd0;
                    code_next       = 16'd0;
                    if (!b[7])
                    begin
                        close_now = 1'b1;
                        close_why = RS_FRAG;
                    end
                    else
                        phase_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    mask_on_next = b[7];
                    if (b[6:0] == LEN_EXT64)
                    begin
                        close_now = 1'b1;
                        close_why = RS_TOO_LONG;
                    end
                    else if (b[6:0] == LEN_EXT16)
                        phase_next = PH_EXT0;
                    else
                    begin
                        length_next = {9'd0, b[6:0]};
                        phase_next  = b[7] ? PH_KEY0 : PH_DATA;
                    end
                end
                PH_EXT0:
                begin
                    length_next = {b, 8'h00};
                    phase_next  = PH_EXT1;
                end
                PH_EXT1:
                begin
                    length_next = ext_len;
                    if (ext_len > max_payload_reg)
                    begin
                        close_now = 1'b1;
                        close_why = RS_TOO_LONG;
                    end
                    else
                        phase_next = mask_on_reg ? PH_KEY0 : PH_DATA;
                end
                PH_KEY0, PH_KEY1, PH_KEY2, PH_KEY3:
                begin
                    key_next[phase_reg[1:0]] = b;
                    phase_next = phase_t'(phase_reg + 4'd1);
                end
                PH_DATA:
                begin
                    if (byte_count_reg >= length_reg)
                    begin
                        close_now = 1'b1;
                        close_why = RS_MISMATCH;
                    end
                    else
                    begin
                        if (byte_count_reg == 16'd0)
                            code_next = {unmasked, 8'h00};
                        else if (byte_count_reg == 16'd1)
                            code_next = {code_reg[15:8], unmasked};
                        emit_byte       = 1'b1;
                        byte_count_next = byte_count_reg + 16'd1;
                    end
                end
                default:
                begin
                end
            endcase

            // Verdict: immediate close, or frame end at segment end
            if (close_now)
            begin
                emit_verdict = 1'b1;
                verdict      = VD_CLOSE;
                reason       = close_why;
                closing_next = 1'b1;
            end
            else if (in_item.segment_end)
            begin
                emit_verdict = 1'b1;
                if (phase_next != PH_DATA || byte_count_next < length_next)
                    verdict = VD_DROP;
                else
                begin
                    unique case (opcode_next)
                        OP_TEXT, OP_BINARY: verdict = VD_DELIVER;
                        OP_PING:            verdict = VD_PONG;
                        OP_PONG:            verdict = VD_IGNORE;
                        OP_CLOSE:
                        begin
                            verdict      = VD_CLOSE;
                            reason       = RS_CLIENT;
                            close_code   = (length_next != 16'd0) ? code_next : 16'd0;
                            closing_next = 1'b1;
                        end
                        default:
                        begin
                            verdict      = VD_CLOSE;
                            reason       = RS_BAD_OP;
                            closing_next = 1'b1;
                        end
                    endcase
                end
            end

            if (in_item.segment_end)
                phase_next = PH_HDR0;
        end
    end

    // Request towards the result formatter
    assign push_valid = accept && (emit_byte || emit_verdict);

    always_comb
    begin
        push_entry.has_byte       = emit_byte;
        push_entry.has_verdict    = emit_verdict;
        push_entry.payload_byte   = unmasked;
        push_entry.frame_opcode   = opcode_next;
        push_entry.payload_length = length_next;
        push_entry.verdict        = verdict;
        push_entry.close_reason   = reason;
        push_entry.close_code     = close_code;
    end

endmodule

[sv/wsdf_queue.sv]
`timescale 1ns / 1ps

module wsdf_queue
    import wsdf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  entry_t push_entry,
    output logic   head_valid,
    output entry_t head_entry,
    input  logic   pop
);

    entry_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // Pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

[sv/wsdf_back.sv]
`timescale 1ns / 1ps

module wsdf_back
    import wsdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  entry_t    head_entry,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    // Set once the payload byte of a two-result request has gone out
    logic byte_done_reg, byte_done_next;
    logic send_byte;
    logic out_accept;

    assign send_byte  = head_entry.has_byte && !byte_done_reg;
    assign out_valid  = head_valid;
    assign out_accept = out_valid && out_ready;
    assign pop        = out_accept && !(send_byte && head_entry.has_verdict);

    always_comb
    begin
        byte_done_next = byte_done_reg;
        if (out_accept)
            byte_done_next = !pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_done_reg <= 1'b0;
        else
            byte_done_reg <= byte_done_next;
    end

    // Result formatting
    always_comb
    begin
        out_item.frame_opcode   = head_entry.frame_opcode;
        out_item.payload_length = head_entry.payload_length;
        if (send_byte)
        begin
            out_item.kind              = KIND_BYTE;
            out_item.payload_byte      = head_entry.payload_byte;
            out_item.verdict           = VD_DELIVER;
            out_item.close_reason      = RS_CLIENT;
            out_item.client_close_code = 16'd0;
            out_item.last_of_run       = !head_entry.has_verdict;
        end
        else
        begin
            out_item.kind              = KIND_VERDICT;
            out_item.payload_byte      = 8'd0;
            out_item.verdict           = head_entry.verdict;
            out_item.close_reason      = head_entry.close_reason;
            out_item.client_close_code = head_entry.close_code;
            out_item.last_of_run       = 1'b1;
        end
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import wsdf_pkg::*;

    localparam int          CLK_PERIOD       = 12;
    localparam int          CHUNK_BYTES      = 260;
    localparam int          NUM_CHUNKS       = 5;
    localparam int          LONG_HOLD_CYCLES = 400;
    localparam int          DRAIN_CYCLES     = 20;
    localparam int          TIMEOUT_NS       = 3_000_000;
    localparam int unsigned NO_CUT           = 100_000;
    localparam logic        FIN              = 1'b1;
    localparam logic        MASKED           = 1'b1;

    // Ways the link gets shut at the end of the run
    typedef enum int {
        END_FRAG,
        END_LEN64,
        END_TOO_LONG,
        END_SURPLUS,
        END_CLIENT,
        END_CLIENT_SHORT,
        END_CLIENT_EMPTY,
        END_BAD_OP
    } ending_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_write_en   = 1'b0;
    logic [15:0] cfg_write_data = '0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    in_item_t    in_item        = '0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    out_item_t   out_item;

    // Bytes waiting to be sent, results still owed by the block
    in_item_t    wire_bytes[$];
    out_item_t   deframed_due[$];
    int unsigned bytes_queued = 0;
    int unsigned mismatches   = 0;

    // Sender and receiver pacing
    int unsigned burst_left     = 0;
    int unsigned gap_left       = 0;
    int unsigned pattern_left   = 0;
    int unsigned hold_left      = 0;
    logic [31:0] ready_pattern  = '1;
    logic        long_hold_req  = 1'b0;
    logic        long_hold_done = 1'b0;

    // Receiver state as the block should hold it
    logic        link_shut    = 1'b0;
    phase_t      rx_phase     = PH_HDR0;
    logic [3:0]  rx_opcode    = '0;
    logic        rx_masked    = 1'b0;
    logic [31:0] rx_key       = '0;
    logic [15:0] rx_length    = '0;
    logic [16:0] rx_count     = '0;
    logic [15:0] rx_status    = '0;
    logic [15:0] length_limit = MAX_PAYLOAD_RESET;

    websocket_frame_deframer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Result built from the current frame state
    function automatic out_item_t frame_result(logic kind, logic [7:0] pb, verdict_t vd,
                                               reason_t rs, logic [15:0] code);
        out_item_t r;
        r.kind              = kind;
        r.payload_byte      = pb;
        r.frame_opcode      = rx_opcode;
        r.verdict           = vd;
        r.close_reason      = rs;
        r.client_close_code = code;
        r.payload_length    = rx_length;
        r.last_of_run       = 1'b0;
        return r;
    endfunction

    function automatic out_item_t close_result(reason_t rs, logic [15:0] code);
        link_shut = 1'b1;
        return frame_result(KIND_VERDICT, 8'h00, VD_CLOSE, rs, code);
    endfunction

    // Advance the receiver by one byte and queue what it should give
    function automatic void deframe_byte(in_item_t req);
        out_item_t  res[$];
        logic [7:0] key_byte;
        logic [7:0] plain;
        int         key_pos;
        if (link_shut)
            return;
        case (rx_phase)
            PH_HDR0:
            begin
                rx_opcode = req.data_byte[3:0];
                rx_masked = 1'b0;
                rx_key    = '0;
                rx_length = '0;
                rx_count  = '0;
                rx_status = '0;
                if (!req.data_byte[7])
                    res.push_back(close_result(RS_FRAG, 16'h0000));
                else
                    rx_phase = PH_HDR1;
            end
            PH_HDR1:
            begin
                rx_masked = req.data_byte[7];
                if (req.data_byte[6:0] == LEN_EXT64)
                    res.push_back(close_result(RS_TOO_LONG, 16'h0000));
                else if (req.data_byte[6:0] == LEN_EXT16)
                    rx_phase = PH_EXT0;
                else
                begin
                    rx_length = {9'd0, req.data_byte[6:0]};
                    rx_phase  = rx_masked ? PH_KEY0 : PH_DATA;
                end
            end
            PH_EXT0:
            begin
                rx_length = {req.data_byte, 8'h00};
                rx_phase  = PH_EXT1;
            end
            PH_EXT1:
            begin
                rx_length[7:0] = req.data_byte;
                if (rx_length > length_limit)
                    res.push_back(close_result(RS_TOO_LONG, 16'h0000));
                else
                    rx_phase = rx_masked ? PH_KEY0 : PH_DATA;
            end
            PH_KEY0, PH_KEY1, PH_KEY2, PH_KEY3:
            begin
                // key arrives most significant byte first
                key_pos = int'(PH_KEY3) - int'(rx_phase);
                rx_key[key_pos * 8 +: 8] = req.data_byte;
                rx_phase = phase_t'(rx_phase + 4'd1);
            end
            PH_DATA:
            begin
                if (rx_count >= {1'b0, rx_length})
                    res.push_back(close_result(RS_MISMATCH, 16'h0000));
                else
                begin
                    key_pos  = 3 - int'(rx_count[1:0]);
                    key_byte = rx_masked ? rx_key[key_pos * 8 +: 8] : 8'h00;
                    plain    = req.data_byte ^ key_byte;
                    if (rx_count == 0)
                        rx_status = {plain, 8'h00};
                    else if (rx_count == 1)
                        rx_status[7:0] = plain;
                    res.push_back(frame_result(KIND_BYTE, plain, VD_DELIVER, RS_CLIENT,
                                               16'h0000));
                    rx_count = rx_count + 17'd1;
                end
            end
            default: ;
        endcase

        // Verdict at segment end
        if (req.segment_end && !link_shut)
        begin
            if (rx_phase != PH_DATA || rx_count < {1'b0, rx_length})
                res.push_back(frame_result(KIND_VERDICT, 8'h00, VD_DROP, RS_CLIENT, 16'h0000));
            else
            begin
                case (rx_opcode)
                    OP_TEXT, OP_BINARY:
                        res.push_back(frame_result(KIND_VERDICT, 8'h00, VD_DELIVER, RS_CLIENT,
                                                   16'h0000));
                    OP_PING:
                        res.push_back(frame_result(KIND_VERDICT, 8'h00, VD_PONG, RS_CLIENT,
                                                   16'h0000));
                    OP_PONG:
                        res.push_back(frame_result(KIND_VERDICT, 8'h00, VD_IGNORE, RS_CLIENT,
                                                   16'h0000));
                    OP_CLOSE:
                        res.push_back(close_result(RS_CLIENT,
                                                   (rx_length != 0) ? rx_status : 16'h0000));
                    default:
                        res.push_back(close_result(RS_BAD_OP, 16'h0000));
                endcase
            end
        end
        if (req.segment_end)
            rx_phase = PH_HDR0;

        if (res.size() != 0)
            res[res.size() - 1].last_of_run = 1'b1;
        foreach (res[i])
            deframed_due.push_back(res[i]);
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic push_byte(input logic [7:0] value, input logic seg_last);
        in_item_t req;
        req.data_byte   = value;
        req.segment_end = seg_last;
        wire_bytes.push_back(req);
        bytes_queued++;
    endtask

    // One frame with random key and payload; cut limits how many bytes go out,
    // surplus adds one byte past the declared payload
    task automatic push_frame(input logic [3:0] op, input logic masked,
                              input int unsigned len, input logic ext,
                              input int unsigned cut, input logic surplus);
        logic [7:0]  head[$];
        int unsigned total;
        int unsigned count;
        logic [7:0]  value;
        head.push_back({FIN, 3'($urandom), op});
        if (ext)
        begin
            head.push_back({masked, LEN_EXT16});
            head.push_back(len[15:8]);
            head.push_back(len[7:0]);
        end
        else
        begin
            head.push_back({masked, len[6:0]});
        end
        if (masked)
            repeat (4) head.push_back(8'($urandom));
        total = head.size() + len;
        count = (cut < total) ? cut : total;
        for (int unsigned i = 0; i < count; i++)
        begin
            value = (i < head.size()) ? head[i] : 8'($urandom);
            push_byte(value, (i == count - 1) && !surplus);
        end
        if (surplus)
            push_byte(8'($urandom), 1'b1);
    endtask

    task automatic wait_until_drained();
        while (wire_bytes.size() != 0 || in_valid || deframed_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_length_limit(input logic [15:0] value);
        wait_until_drained();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        length_limit = value;
    endtask

    // Sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_item    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (wire_bytes.size() != 0)
            begin
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 48);
                in_item  <= wire_bytes.pop_front();
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern refreshed when pattern_left runs out, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern_left = 64;
                    case ($urandom_range(0, 3))
                        0:       ready_pattern = '1;
                        1:       ready_pattern = $urandom;
                        2:       ready_pattern = $urandom | $urandom;
                        default: ready_pattern = $urandom & $urandom;
                    endcase
                end
                pattern_left--;
                out_ready <= ready_pattern[pattern_left % 32];
            end
        end
    end

    // Monitor: predict on each accepted byte, check each accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                deframe_byte(in_item);
            if (out_valid && out_ready)
            begin
                if (deframed_due.size() == 0)
                begin
                    $error("unexpected result request: 0x%0h", out_item);
                    mismatches++;
                end
                else
                begin
                    check_field("kind", 16'(deframed_due[0].kind), 16'(out_item.kind));
                    check_field("payload_byte", 16'(deframed_due[0].payload_byte),
                                16'(out_item.payload_byte));
                    check_field("frame_opcode", 16'(deframed_due[0].frame_opcode),
                                16'(out_item.frame_opcode));
                    check_field("verdict", 16'(deframed_due[0].verdict),
                                16'(out_item.verdict));
                    check_field("close_reason", 16'(deframed_due[0].close_reason),
                                16'(out_item.close_reason));
                    check_field("client_close_code", deframed_due[0].client_close_code,
                                out_item.client_close_code);
                    check_field("payload_length", deframed_due[0].payload_length,
                                out_item.payload_length);
                    check_field("last_of_run", 16'(deframed_due[0].last_of_run),
                                16'(out_item.last_of_run));
                    void'(deframed_due.pop_front());
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int unsigned chunk_start;
        logic [15:0] limit_value;
        logic [3:0]  op;
        logic        masked;
        logic        ext;
        int unsigned len;
        int unsigned head_len;
        int unsigned total;
        int unsigned cut_top;
        ending_t     ending;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames at the reset limit
        // empty unmasked binary
        push_byte({FIN, 3'b000, OP_BINARY}, 1'b0);
        push_byte({1'b0, 7'd0}, 1'b1);
        // masked ping, one byte
        push_byte({FIN, 3'b111, OP_PING}, 1'b0);
        push_byte({MASKED, 7'd1}, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'h56, 1'b0);
        push_byte(8'h78, 1'b0);
        push_byte(8'hFF, 1'b1);
        // unmasked pong passes bytes unchanged
        push_byte({FIN, 3'b000, OP_PONG}, 1'b0);
        push_byte({1'b0, 7'd1}, 1'b0);
        push_byte(8'hFF, 1'b1);
        // text with 16-bit extended length
        push_byte({FIN, 3'b000, OP_TEXT}, 1'b0);
        push_byte({1'b0, LEN_EXT16}, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b1);
        // segment ends inside the header
        push_byte({FIN, 3'b000, OP_TEXT}, 1'b1);
        // segment ends inside the payload, all-ones key
        push_byte({FIN, 3'b000, OP_BINARY}, 1'b0);
        push_byte({MASKED, 7'd5}, 1'b0);
        repeat (4) push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);

        // Random frames, limit changed between chunks
        for (int chunk = 0; chunk < NUM_CHUNKS; chunk++)
        begin
            if (chunk == 0)
                limit_value = 16'h0000;
            else if (chunk == 1)
                limit_value = 16'hFFFF;
            else
                limit_value = 16'($urandom);
            write_length_limit(limit_value);
            if (chunk == 2)
                long_hold_req = 1'b1;
            chunk_start = bytes_queued;
            while (bytes_queued - chunk_start < CHUNK_BYTES)
            begin
                masked = ($urandom_range(0, 4) != 0);
                ext    = ($urandom_range(0, 6) == 0);
                if ($urandom_range(0, 6) == 0)
                begin
                    // truncated frame, any opcode
                    op       = 4'($urandom);
                    len      = ext ? $urandom_range(0, length_limit) : $urandom_range(0, 125);
                    head_len = 2 + (ext ? 2 : 0) + (masked ? 4 : 0);
                    total    = head_len + len;
                    cut_top  = (total - 1 < head_len + 6) ? total - 1 : head_len + 6;
                    push_frame(op, masked, len, ext, $urandom_range(1, cut_top), 1'b0);
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       op = OP_TEXT;
                        1:       op = OP_BINARY;
                        2:       op = OP_PING;
                        default: op = OP_PONG;
                    endcase
                    if (ext)
                        len = $urandom_range(0, (length_limit < 40) ? length_limit : 40);
                    else if ($urandom_range(0, 9) == 0)
                        len = $urandom_range(0, 125);
                    else
                        len = $urandom_range(0, 12);
                    push_frame(op, masked, len, ext, NO_CUT, 1'b0);
                end
            end
        end

        // One closing frame, then traffic that must be ignored
        ending = ending_t'($urandom_range(0, 7));
        if (ending == END_TOO_LONG && length_limit == 16'hFFFF)
            ending = END_SURPLUS;
        case (ending)
            END_FRAG:
                push_byte({1'b0, 3'($urandom), 4'($urandom)}, 1'b1);
            END_LEN64:
            begin
                push_byte({FIN, 3'b000, OP_BINARY}, 1'b0);
                push_byte({1'($urandom), LEN_EXT64}, 1'b1);
            end
            END_TOO_LONG:
                push_frame(OP_TEXT, 1'($urandom), int'(length_limit) + 1, 1'b1, 4, 1'b0);
            END_SURPLUS:
                push_frame(OP_BINARY, 1'($urandom), $urandom_range(0, 6), 1'b0, NO_CUT, 1'b1);
            END_CLIENT:
                push_frame(OP_CLOSE, MASKED, $urandom_range(2, 8), 1'b0, NO_CUT, 1'b0);
            END_CLIENT_SHORT:
                push_frame(OP_CLOSE, MASKED, 1, 1'b0, NO_CUT, 1'b0);
            END_CLIENT_EMPTY:
                push_frame(OP_CLOSE, 1'($urandom), 0, 1'b0, NO_CUT, 1'b0);
            default:
            begin
                do
                    op = 4'($urandom);
                while (op == OP_TEXT || op == OP_BINARY || op == OP_CLOSE ||
                       op == OP_PING || op == OP_PONG);
                push_frame(op, 1'($urandom), $urandom_range(0, 5), 1'b0, NO_CUT, 1'b0);
            end
        endcase
        push_frame(OP_TEXT, MASKED, 3, 1'b0, NO_CUT, 1'b0);
        repeat (6) push_byte(8'($urandom), 1'($urandom));

        wait_until_drained();
        if (mismatches == 0)
            $display("** websocket_frame_deframer: PASSED **");
        else
            $display("** websocket_frame_deframer: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("** websocket_frame_deframer: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
sv/wsdf_pkg.sv
sv/wsdf_front.sv
sv/wsdf_queue.sv
sv/wsdf_back.sv
sv/websocket_frame_deframer.sv
tb/sv/testbench.sv
